/* hdl/jtl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_pkg
// Types, codes and character helpers shared by the JSON token lexer modules.
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_NUM  = 3'd4,
        MODE_WORD = 3'd5
    } t_mode;

    localparam logic [3:0] KIND_EOF    = 4'd0;
    localparam logic [3:0] KIND_LBRACK = 4'd1;
    localparam logic [3:0] KIND_RBRACK = 4'd2;
    localparam logic [3:0] KIND_LBRACE = 4'd3;
    localparam logic [3:0] KIND_RBRACE = 4'd4;
    localparam logic [3:0] KIND_COLON  = 4'd5;
    localparam logic [3:0] KIND_COMMA  = 4'd6;
    localparam logic [3:0] KIND_STRING = 4'd7;
    localparam logic [3:0] KIND_NUMBER = 4'd8;
    localparam logic [3:0] KIND_WORD   = 4'd9;

    localparam logic [1:0] EV_SINGLE  = 2'd0;
    localparam logic [1:0] EV_BEGIN   = 2'd1;
    localparam logic [1:0] EV_CONTENT = 2'd2;
    localparam logic [1:0] EV_END     = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  ev;
        logic [15:0] content;
    } t_event;

    // Up to three events produced by one request, in order from index 0.
    typedef struct packed {
        logic [1:0]       count;
        t_event [2:0]     evs;
    } t_bundle;

    function automatic t_bundle add_event(t_bundle b, logic [3:0] kind, logic [1:0] ev,
                                          logic [15:0] content);
        t_bundle r;
        r = b;
        if (b.count != 2'd3) begin
            r.evs[b.count].kind    = kind;
            r.evs[b.count].ev      = ev;
            r.evs[b.count].content = content;
            r.count                = b.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [3:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // Events for the first byte of a token, appended to b.
    function automatic t_bundle start_events(t_bundle b, logic [7:0] c);
        t_bundle r;
        r = b;
        if (is_space(c)) begin
            r = b;
        end else if (c == CH_LBRACK) begin
            r = add_event(b, KIND_LBRACK, EV_SINGLE, 16'h0000);
        end else if (c == CH_RBRACK) begin
            r = add_event(b, KIND_RBRACK, EV_SINGLE, 16'h0000);
        end else if (c == CH_LBRACE) begin
            r = add_event(b, KIND_LBRACE, EV_SINGLE, 16'h0000);
        end else if (c == CH_RBRACE) begin
            r = add_event(b, KIND_RBRACE, EV_SINGLE, 16'h0000);
        end else if (c == CH_COLON) begin
            r = add_event(b, KIND_COLON, EV_SINGLE, 16'h0000);
        end else if (c == CH_COMMA) begin
            r = add_event(b, KIND_COMMA, EV_SINGLE, 16'h0000);
        end else if (c == CH_QUOTE) begin
            r = add_event(b, KIND_STRING, EV_BEGIN, 16'h0000);
        end else if ((c == CH_MINUS) || is_digit(c)) begin
            r = add_event(b, KIND_NUMBER, EV_BEGIN, 16'h0000);
            r = add_event(r, KIND_NUMBER, EV_CONTENT, {8'h00, c});
        end else begin
            r = add_event(b, KIND_WORD, EV_BEGIN, 16'h0000);
            r = add_event(r, KIND_WORD, EV_CONTENT, {8'h00, c});
        end
        return r;
    endfunction

    function automatic t_mode start_mode(logic [7:0] c);
        t_mode m;
        m = MODE_IDLE;
        if (is_space(c) || (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LBRACE) ||
            (c == CH_RBRACE) || (c == CH_COLON) || (c == CH_COMMA)) begin
            m = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
            m = MODE_STR;
        end else if ((c == CH_MINUS) || is_digit(c)) begin
            m = MODE_NUM;
        end else begin
            m = MODE_WORD;
        end
        return m;
    endfunction

endpackage

/* hdl/jtl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_front
// Accepts text bytes and end markers, runs the lexer state and packs the
// events caused by each request into one bundle for the queue.
// ----------------------------------------------------------------------------
module jtl_front
    import jtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_marker,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_bundle     o_bundle
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_seen, n_hex_seen;
    logic [15:0] r_acc, n_acc;
    logic        r_finished, n_finished;
    t_bundle     n_bundle;
    logic        accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    always_comb begin
        logic [15:0] acc_shift;
        acc_shift  = {r_acc[11:0], hex_value(i_text_byte)};
        n_mode     = r_mode;
        n_hex_seen = r_hex_seen;
        n_acc      = r_acc;
        n_finished = r_finished;
        n_bundle   = '0;
        if (i_end_marker) begin
            unique case (r_mode)
                MODE_STR, MODE_ESC, MODE_HEX: begin
                    n_bundle = add_event(n_bundle, KIND_STRING, EV_END, 16'h0000);
                end
                MODE_NUM: begin
                    n_bundle = add_event(n_bundle, KIND_NUMBER, EV_END, 16'h0000);
                end
                MODE_WORD: begin
                    n_bundle = add_event(n_bundle, KIND_WORD, EV_END, 16'h0000);
                end
                default: begin
                    n_bundle = n_bundle;
                end
            endcase
            n_bundle   = add_event(n_bundle, KIND_EOF, EV_SINGLE, 16'h0000);
            n_mode     = MODE_IDLE;
            n_hex_seen = 2'd0;
            n_acc      = 16'h0000;
            n_finished = 1'b1;
        end else if (!r_finished) begin
            unique case (r_mode)
                MODE_STR: begin
                    if (i_text_byte == CH_QUOTE) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_END, 16'h0000);
                        n_mode   = MODE_IDLE;
                    end else if (i_text_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT,
                                             {8'h00, i_text_byte});
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_STR;
                    if ((i_text_byte == CH_QUOTE) || (i_text_byte == CH_BSLASH) ||
                        (i_text_byte == CH_SLASH)) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT,
                                             {8'h00, i_text_byte});
                    end else if (i_text_byte == CH_LOW_B) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT, 16'h0008);
                    end else if (i_text_byte == CH_LOW_F) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT, 16'h000C);
                    end else if (i_text_byte == CH_LOW_N) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT, 16'h000A);
                    end else if (i_text_byte == CH_LOW_R) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT, 16'h000D);
                    end else if (i_text_byte == CH_LOW_T) begin
                        n_bundle = add_event(n_bundle, KIND_STRING, EV_CONTENT, 16'h0009);
                    end else if (i_text_byte == CH_LOW_U) begin
                        n_mode     = MODE_HEX;
                        n_hex_seen = 2'd0;
                        n_acc      = 16'h0000;
                    end
                end
                MODE_HEX: begin
                    if (r_hex_seen == 2'd3) begin
                        n_bundle   = add_event(n_bundle, KIND_STRING, EV_CONTENT, acc_shift);
                        n_hex_seen = 2'd0;
                        n_acc      = 16'h0000;
                        n_mode     = MODE_STR;
                    end else begin
                        n_acc      = acc_shift;
                        n_hex_seen = r_hex_seen + 2'd1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(i_text_byte) || (i_text_byte == CH_PLUS) ||
                        (i_text_byte == CH_MINUS) || (i_text_byte == CH_DOT) ||
                        (i_text_byte == CH_LOW_E) || (i_text_byte == CH_UPPER_E)) begin
                        n_bundle = add_event(n_bundle, KIND_NUMBER, EV_CONTENT,
                                             {8'h00, i_text_byte});
                    end else begin
                        n_bundle = add_event(n_bundle, KIND_NUMBER, EV_END, 16'h0000);
                        n_bundle = start_events(n_bundle, i_text_byte);
                        n_mode   = start_mode(i_text_byte);
                    end
                end
                MODE_WORD: begin
                    if (is_digit(i_text_byte) || is_alpha(i_text_byte) ||
                        (i_text_byte == CH_UNDER) || (i_text_byte == CH_DOLLAR)) begin
                        n_bundle = add_event(n_bundle, KIND_WORD, EV_CONTENT,
                                             {8'h00, i_text_byte});
                    end else begin
                        n_bundle = add_event(n_bundle, KIND_WORD, EV_END, 16'h0000);
                        n_bundle = start_events(n_bundle, i_text_byte);
                        n_mode   = start_mode(i_text_byte);
                    end
                end
                default: begin
                    n_bundle = start_events(n_bundle, i_text_byte);
                    n_mode   = start_mode(i_text_byte);
                end
            endcase
        end
    end

    assign o_push   = accept && (n_bundle.count != 2'd0);
    assign o_bundle = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_hex_seen <= 2'd0;
            r_acc      <= 16'h0000;
            r_finished <= 1'b0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_hex_seen <= n_hex_seen;
            r_acc      <= n_acc;
            r_finished <= n_finished;
        end
    end

endmodule

/* hdl/jtl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_queue
// Short first-in first-out queue of event bundles between front and back.
// ----------------------------------------------------------------------------
module jtl_queue
    import jtl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_bundle
);

    t_bundle                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wptr, r_rptr;
    logic [QUEUE_AW:0]      r_count;
    logic                   do_push, do_pop;

    assign o_full   = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/jtl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_back
// Pops queued bundles; sends their events one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module jtl_back
    import jtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_bundle     i_q_bundle,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [1:0]  o_event_res,
    output logic [15:0] o_content,
    output logic        o_last_of_run
);

    t_bundle    r_bundle;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       fire, last;
    t_event     cur;

    assign cur           = r_bundle.evs[r_idx];
    assign last          = (r_idx == (r_bundle.count - 2'd1));
    assign fire          = r_valid && i_ready;
    assign o_pop         = i_q_valid && (!r_valid || (fire && last));
    assign o_valid       = r_valid;
    assign o_token_kind  = cur.kind;
    assign o_event_res   = cur.ev;
    assign o_content     = cur.content;
    assign o_last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_q_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

/* hdl/json_token_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_lexer
// Streaming JSON tokenizer: text bytes in, token events out.
// ----------------------------------------------------------------------------
// The input channel takes one request per cycle: a text byte, or an end
// marker with i_end_marker high. The output channel delivers token events
// (kind, event, content, last_of_run), one per cycle, with valid and ready.
// A request that causes no event, such as whitespace, only updates the state.
// The front classifies each request in the cycle it is accepted and writes
// its one to three events as a bundle into a four-entry queue. The back
// reads one bundle into its output register and presents its events in
// order from there. Requests with one event each sustain one request per
// cycle while i_ready stays high; a bundle of several events holds the output
// until all are taken; the queue absorbs these bursts before o_ready drops.
// When the receiver holds i_ready low, the queue fills and o_ready falls;
// no event is lost. Reset clears the lexer state, the queue pointers and
// o_valid; the block accepts requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module json_token_lexer
    import jtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_marker,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [1:0]  o_event_res,
    output logic [15:0] o_content,
    output logic        o_last_of_run
);

    logic    push, full, pop, q_valid;
    t_bundle push_bundle, q_bundle;

    jtl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_byte  (i_text_byte),
        .i_end_marker (i_end_marker),
        .i_queue_full (full),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    jtl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_full   (full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    jtl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_bundle    (q_bundle),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_event_res   (o_event_res),
        .o_content     (o_content),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* tb/jtl_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_event_checker
// Watches both channels of the JSON token lexer and checks every token event.
// Each accepted request runs through a local model of the lexer. The model
// queues the one to three events that the request should cause, and each
// accepted event is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module jtl_event_checker
    import jtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_byte,
    input  logic        i_req_end,
    input  logic        i_evt_valid,
    input  logic        i_evt_ready,
    input  logic [3:0]  i_evt_kind,
    input  logic [1:0]  i_evt_code,
    input  logic [15:0] i_evt_content,
    input  logic        i_evt_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  code;
        logic [15:0] content;
        logic        last;
    } t_token_event;

    t_token_event expected_events[$];
    t_token_event step_buf [0:2];
    t_token_event want_event;
    int           step_n = 0;
    int           fail_total = 0;
    int           checked_total = 0;
    int           pending_total = 0;

    t_mode        lex_mode = MODE_IDLE;
    logic [1:0]   hex_seen = 2'd0;
    logic [15:0]  code_unit = 16'h0000;
    logic         input_done = 1'b0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    function automatic logic digit_char(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic letter_char(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic number_char(logic [7:0] c);
        return digit_char(c) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT) ||
               (c == CH_LOW_E) || (c == CH_UPPER_E);
    endfunction

    function automatic logic word_char(logic [7:0] c);
        return digit_char(c) || letter_char(c) || (c == CH_UNDER) || (c == CH_DOLLAR);
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (digit_char(c)) begin
            v = c - "0";
        end else if ((c >= "A") && (c <= "F")) begin
            v = c - "A" + 8'd10;
        end else if ((c >= "a") && (c <= "f")) begin
            v = c - "a" + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic void add_step_event(logic [3:0] kind, logic [1:0] code,
                                           logic [15:0] value);
        if (step_n < 3) begin
            step_buf[step_n].kind    = kind;
            step_buf[step_n].code    = code;
            step_buf[step_n].content = value;
            step_buf[step_n].last    = 1'b0;
            step_n = step_n + 1;
        end
    endfunction

    function automatic void open_token(logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
            CH_LBRACK: add_step_event(KIND_LBRACK, EV_SINGLE, 16'h0000);
            CH_RBRACK: add_step_event(KIND_RBRACK, EV_SINGLE, 16'h0000);
            CH_LBRACE: add_step_event(KIND_LBRACE, EV_SINGLE, 16'h0000);
            CH_RBRACE: add_step_event(KIND_RBRACE, EV_SINGLE, 16'h0000);
            CH_COLON:  add_step_event(KIND_COLON, EV_SINGLE, 16'h0000);
            CH_COMMA:  add_step_event(KIND_COMMA, EV_SINGLE, 16'h0000);
            CH_QUOTE: begin
                add_step_event(KIND_STRING, EV_BEGIN, 16'h0000);
                lex_mode = MODE_STR;
            end
            default: begin
                if ((c == CH_MINUS) || digit_char(c)) begin
                    add_step_event(KIND_NUMBER, EV_BEGIN, 16'h0000);
                    add_step_event(KIND_NUMBER, EV_CONTENT, {8'h00, c});
                    lex_mode = MODE_NUM;
                end else begin
                    add_step_event(KIND_WORD, EV_BEGIN, 16'h0000);
                    add_step_event(KIND_WORD, EV_CONTENT, {8'h00, c});
                    lex_mode = MODE_WORD;
                end
            end
        endcase
    endfunction

    function automatic void take_escape_char(logic [7:0] c);
        lex_mode = MODE_STR;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_step_event(KIND_STRING, EV_CONTENT, {8'h00, c});
            CH_LOW_B: add_step_event(KIND_STRING, EV_CONTENT, 16'h0008);
            CH_LOW_F: add_step_event(KIND_STRING, EV_CONTENT, {8'h00, CH_FF});
            CH_LOW_N: add_step_event(KIND_STRING, EV_CONTENT, {8'h00, CH_LF});
            CH_LOW_R: add_step_event(KIND_STRING, EV_CONTENT, {8'h00, CH_CR});
            CH_LOW_T: add_step_event(KIND_STRING, EV_CONTENT, {8'h00, CH_TAB});
            CH_LOW_U: begin
                lex_mode  = MODE_HEX;
                hex_seen  = 2'd0;
                code_unit = 16'h0000;
            end
            default: ;
        endcase
    endfunction

    function automatic void take_text_byte(logic [7:0] c);
        case (lex_mode)
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    add_step_event(KIND_STRING, EV_END, 16'h0000);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    lex_mode = MODE_ESC;
                end else begin
                    add_step_event(KIND_STRING, EV_CONTENT, {8'h00, c});
                end
            end
            MODE_ESC: take_escape_char(c);
            MODE_HEX: begin
                code_unit = {code_unit[11:0], hex_nibble(c)};
                if (hex_seen == 2'd3) begin
                    add_step_event(KIND_STRING, EV_CONTENT, code_unit);
                    hex_seen  = 2'd0;
                    code_unit = 16'h0000;
                    lex_mode  = MODE_STR;
                end else begin
                    hex_seen = hex_seen + 2'd1;
                end
            end
            MODE_NUM: begin
                if (number_char(c)) begin
                    add_step_event(KIND_NUMBER, EV_CONTENT, {8'h00, c});
                end else begin
                    add_step_event(KIND_NUMBER, EV_END, 16'h0000);
                    lex_mode = MODE_IDLE;
                    open_token(c);
                end
            end
            MODE_WORD: begin
                if (word_char(c)) begin
                    add_step_event(KIND_WORD, EV_CONTENT, {8'h00, c});
                end else begin
                    add_step_event(KIND_WORD, EV_END, 16'h0000);
                    lex_mode = MODE_IDLE;
                    open_token(c);
                end
            end
            default: begin
                lex_mode = MODE_IDLE;
                open_token(c);
            end
        endcase
    endfunction

    function automatic void predict_request(logic [7:0] c, logic is_end);
        step_n = 0;
        if (is_end) begin
            case (lex_mode)
                MODE_STR, MODE_ESC, MODE_HEX: add_step_event(KIND_STRING, EV_END, 16'h0000);
                MODE_NUM:  add_step_event(KIND_NUMBER, EV_END, 16'h0000);
                MODE_WORD: add_step_event(KIND_WORD, EV_END, 16'h0000);
                default: ;
            endcase
            add_step_event(KIND_EOF, EV_SINGLE, 16'h0000);
            lex_mode   = MODE_IDLE;
            hex_seen   = 2'd0;
            code_unit  = 16'h0000;
            input_done = 1'b1;
        end else if (!input_done) begin
            take_text_byte(c);
        end
        if (step_n > 0) begin
            step_buf[step_n - 1].last = 1'b1;
        end
        for (int k = 0; k < step_n; k++) begin
            expected_events.push_back(step_buf[k]);
        end
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_total = fail_total + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_mode   = MODE_IDLE;
            hex_seen   = 2'd0;
            code_unit  = 16'h0000;
            input_done = 1'b0;
            expected_events.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_byte, i_req_end);
            end
            if (i_evt_valid && i_evt_ready) begin
                checked_total = checked_total + 1;
                if (expected_events.size() == 0) begin
                    $error("Token event kind 0x%0h arrived with none expected", i_evt_kind);
                    fail_total = fail_total + 1;
                end else begin
                    want_event = expected_events.pop_front();
                    check_field("token_kind", {12'h000, want_event.kind}, {12'h000, i_evt_kind});
                    check_field("event_res", {14'h0000, want_event.code},
                                {14'h0000, i_evt_code});
                    check_field("content", want_event.content, i_evt_content);
                    check_field("last_of_run", {15'h0000, want_event.last},
                                {15'h0000, i_evt_last});
                end
            end
        end
        pending_total = expected_events.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the JSON token lexer.
// A directed request sequence covers every non-EOF token type, whitespace, escapes,
// bad hex digits and tokens ended by the next byte. A random stream of JSON
// fragments and noise bytes follows, and the run closes with end markers and
// bytes after the end. The sender works in bursts; the receiver stalls in
// changing patterns. A separate checker module judges every token event.
// ----------------------------------------------------------------------------
module tb_top;
    import jtl_pkg::*;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_end_marker = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [1:0]  o_event_res;
    logic [15:0] o_content;
    logic        o_last_of_run;

    int          fail_total;
    int          pending_events;
    int          checked_events;

    logic [8:0]  request_plan[$];
    t_sink_mode  sink_mode = SINK_OPEN;
    int          sink_left = 0;

    localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
    localparam string NUMBER_CHARS = "0123456789+-.eE";
    localparam string WORD_CHARS   =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$";
    localparam string ESCAPE_CHARS = "\"\\/bfnrt";
    localparam string PUNCT_CHARS  = "[]{}:,";

    logic [7:0]  space_chars [0:5] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    json_token_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_marker  (i_end_marker),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_event_res   (o_event_res),
        .o_content     (o_content),
        .o_last_of_run (o_last_of_run)
    );

    jtl_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_byte    (i_text_byte),
        .i_req_end     (i_end_marker),
        .i_evt_valid   (o_valid),
        .i_evt_ready   (i_ready),
        .i_evt_kind    (o_token_kind),
        .i_evt_code    (o_event_res),
        .i_evt_content (o_content),
        .i_evt_last    (o_last_of_run),
        .o_fail_count  (fail_total),
        .o_pending     (pending_events),
        .o_checked     (checked_events)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(30, 150);
        end
        sink_left = sink_left - 1;
        case (sink_mode)
            SINK_OPEN:   i_ready <= 1'b1;
            SINK_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
            default:     i_ready <= ((sink_left % 9) > 2);
        endcase
    end

    task automatic plan_byte(input logic [7:0] b);
        request_plan.push_back({1'b0, b});
    endtask

    task automatic plan_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            plan_byte(s[k]);
        end
    endtask

    task automatic plan_end_marker();
        logic [7:0] filler;
        filler = 8'($urandom_range(0, 255));
        request_plan.push_back({1'b1, filler});
    endtask

    task automatic plan_string_token();
        int         body_len;
        int         pick;
        logic [7:0] b;
        body_len = $urandom_range(0, 6);
        plan_byte(CH_QUOTE);
        for (int k = 0; k < body_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
                if ((b == CH_QUOTE) || (b == CH_BSLASH)) begin
                    b = CH_UNDER;
                end
                plan_byte(b);
            end else if (pick < 60) begin
                b = 8'($urandom_range(0, 255));
                if ((b == CH_QUOTE) || (b == CH_BSLASH)) begin
                    b = 8'hFF;
                end
                plan_byte(b);
            end else if (pick < 78) begin
                plan_byte(CH_BSLASH);
                plan_byte(ESCAPE_CHARS[$urandom_range(0, ESCAPE_CHARS.len() - 1)]);
            end else if (pick < 86) begin
                b = 8'($urandom_range(0, 255));
                if ((b == CH_LOW_U) || (b == CH_LOW_B) || (b == CH_LOW_F) ||
                    (b == CH_LOW_N) || (b == CH_LOW_R) || (b == CH_LOW_T) ||
                    (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH)) begin
                    b = "q";
                end
                plan_byte(CH_BSLASH);
                plan_byte(b);
            end else begin
                plan_byte(CH_BSLASH);
                plan_byte(CH_LOW_U);
                for (int d = 0; d < 4; d++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        plan_byte(8'($urandom_range(0, 255)));
                    end else begin
                        plan_byte(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
                    end
                end
            end
        end
        plan_byte(CH_QUOTE);
    endtask

    task automatic plan_random_token();
        int         pick;
        int         run_len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            run_len = $urandom_range(1, 3);
            for (int k = 0; k < run_len; k++) begin
                plan_byte(space_chars[$urandom_range(0, 5)]);
            end
        end else if (pick < 30) begin
            plan_byte(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]);
        end else if (pick < 55) begin
            plan_string_token();
        end else if (pick < 72) begin
            if ($urandom_range(0, 3) == 0) begin
                plan_byte(CH_MINUS);
            end else begin
                plan_byte(NUMBER_CHARS[$urandom_range(0, 9)]);
            end
            run_len = $urandom_range(0, 5);
            for (int k = 0; k < run_len; k++) begin
                plan_byte(NUMBER_CHARS[$urandom_range(0, NUMBER_CHARS.len() - 1)]);
            end
        end else if (pick < 90) begin
            case ($urandom_range(0, 5))
                0: plan_text("true");
                1: plan_text("false");
                2: plan_text("null");
                default: begin
                    b = WORD_CHARS[$urandom_range(0, 51)];
                    if ($urandom_range(0, 7) == 0) begin
                        b = ($urandom_range(0, 1) == 0) ? CH_UNDER : CH_DOLLAR;
                    end
                    plan_byte(b);
                    run_len = $urandom_range(0, 6);
                    for (int k = 0; k < run_len; k++) begin
                        plan_byte(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
                    end
                end
            endcase
        end else begin
            run_len = $urandom_range(1, 3);
            for (int k = 0; k < run_len; k++) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE) begin
                    b = 8'h00;
                end
                plan_byte(b);
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            plan_byte(space_chars[$urandom_range(0, 5)]);
        end
    endtask

    initial begin
        int directed_n;
        int random_n;
        int tail_n;
        int burst_left;
        int gap;
        int wait_cycles;
        int leftover_fails;

        leftover_fails = 0;

        plan_text("[]{}:,");
        for (int k = 0; k < 6; k++) begin
            plan_byte(space_chars[k]);
        end
        // A number ended by a word, a word ended by a string, then an
        // unknown escape and a code unit with one bad hex digit.
        plan_text("-9e+x$\"\\q\\uGf0A\"");
        directed_n = request_plan.size();

        while (request_plan.size() < 145) begin
            plan_random_token();
        end
        random_n = request_plan.size() - directed_n;

        // An open string with a partial code unit at the end of input, a
        // repeated end marker, and bytes that arrive after the end.
        plan_byte(CH_SPACE);
        plan_text("\"k\\u4");
        plan_end_marker();
        plan_end_marker();
        plan_text("x9");
        plan_byte(8'hFF);
        plan_byte(8'h00);
        plan_end_marker();
        tail_n = request_plan.size() - directed_n - random_n;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 20);
        for (int idx = 0; idx < request_plan.size(); idx++) begin
            i_valid      <= 1'b1;
            i_text_byte  <= request_plan[idx][7:0];
            i_end_marker <= request_plan[idx][8];
            @(posedge i_clk);
            while (!o_ready) begin
                @(posedge i_clk);
            end
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
        end
        i_valid <= 1'b0;

        for (wait_cycles = 0; (wait_cycles < 4000) && (pending_events != 0);
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (pending_events != 0) begin
            $error("%0d token events expected but never delivered", pending_events);
            leftover_fails = 1;
        end

        $display("Sent %0d requests: %0d directed, %0d random JSON fragments, %0d at end of input.",
                 request_plan.size(), directed_n, random_n, tail_n);
        $display("Checked %0d token events under bursty input and stalling output.",
                 checked_events);
        if ((fail_total == 0) && (leftover_fails == 0)) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/jtl_pkg.sv
hdl/jtl_front.sv
hdl/jtl_queue.sv
hdl/jtl_back.sv
hdl/json_token_lexer.sv
tb/jtl_event_checker.sv
tb/tb_top.sv
